// File: rtl/sdps_pkg.sv
`default_nettype none

package sdps_pkg;

   // Number of drive slots served by the sequencer.
   localparam int NUM_SLOTS = 4;
   // Width of a slot number on the request and response streams.
   localparam int SLOT_W = 2;
   // Width of the spin-up tick count and of the timer.
   localparam int TICK_W = 16;
   // Width of the queue fill count, which must also hold NUM_SLOTS itself.
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic [TICK_W-1:0] SPIN_RESET_TICKS = TICK_W'(5000);

   typedef enum logic {
      CMD_PRESENCE = 1'b0,
      CMD_TICK     = 1'b1
   } cmd_type;

   // Broadcast from the control logic to every queue cell.
   typedef struct packed {
      logic              remove;   // a removal request is being processed
      logic              push;     // the request slot joins the tail of the queue
      logic [SLOT_W-1:0] slot;     // slot of the current request
   } queue_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/sdps_cell.sv
`default_nettype none

// One place of the wait queue. A cell drops out of line by taking its upper
// neighbour's entry whenever it, or any cell below it, loses its own entry.
module sdps_cell (
   input  wire logic                         clock,
   input  wire sdps_pkg::queue_ctrl_type     ctrl_in,
   input  wire logic                         occupied_in,
   input  wire logic                         push_here_in,
   input  wire logic [sdps_pkg::SLOT_W-1:0]  next_entry_in,
   input  wire logic                         shift_in,
   output logic      [sdps_pkg::SLOT_W-1:0]  entry_out,
   output logic                              shift_out
);
   import sdps_pkg::*;

   logic [SLOT_W-1:0] entry_ff;
   logic [SLOT_W-1:0] entry_in;
   logic              own_match;

   assign own_match = occupied_in && ctrl_in.remove && (entry_ff == ctrl_in.slot);
   assign shift_out = shift_in || own_match;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (shift_out) begin
         entry_in = next_entry_in;
      end else if (push_here_in) begin
         entry_in = ctrl_in.slot;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// File: rtl/staggered_drive_power_sequencer.sv
// Latency: the power commands of a request appear on the response stream in
// the cycle after the request is taken, one command per cycle when accepted.
// Throughput: with the response side ready, one request every cycle when it
// gives one command or none; one that gives two holds the next back until its
// first command has left the buffer. Reset is synchronous and active high; it
// clears the spin-up state, the queue count and mask, and loads 5000 ticks.
`default_nettype none

module staggered_drive_power_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,   // spin_up_ticks

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [1:0] slot, [2] present, [7:3] zero
   input  wire logic        req_tuser,     // cmd

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,     // [1:0] power_slot, [2] turn_on, [7:3] zero
   output logic             rsp_tlast      // last
);
   import sdps_pkg::*;

   // One power command waiting on the response stream.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              turn_on;
      logic              last;
   } result_type;

   localparam int RES_CNT_W = 2;

   // Configuration and spin-up state.
   logic [TICK_W-1:0]    spin_ticks_ff;
   logic                 spin_valid_ff, spin_valid_in;
   logic [SLOT_W-1:0]    spin_slot_ff, spin_slot_in;
   logic [TICK_W-1:0]    spin_timer_ff, spin_timer_in;
   logic [CNT_W-1:0]     queue_count_ff, queue_count_in;
   logic [NUM_SLOTS-1:0] queued_mask_ff, queued_mask_in;

   // Response buffer: up to two commands, the oldest in entry zero.
   result_type           res_ff [2];
   result_type           res_in [2];
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic                 req_accept;
   logic                 rsp_take;
   logic [SLOT_W-1:0]    req_slot;
   logic                 req_present;
   logic                 pop;
   queue_ctrl_type       queue_ctrl;
   logic [SLOT_W-1:0]    head_slot;

   // The queue as a row of cells; cell zero holds the head.
   logic [SLOT_W-1:0]    cell_entry [NUM_SLOTS];
   logic [SLOT_W-1:0]    cell_next  [NUM_SLOTS];
   logic                 cell_shift [NUM_SLOTS+1];
   logic                 cell_occupied [NUM_SLOTS];
   logic                 cell_push [NUM_SLOTS];

   assign req_slot    = req_tdata[SLOT_W-1:0];
   assign req_present = req_tdata[SLOT_W];

   // A new request may enter once the buffer is empty, or as its final command
   // leaves in the same cycle.
   assign req_tready = (res_cnt_ff == RES_CNT_W'(0)) ||
                       ((res_cnt_ff == RES_CNT_W'(1)) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = (res_cnt_ff != RES_CNT_W'(0));
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{(8 - SLOT_W - 1){1'b0}}, res_ff[0].turn_on, res_ff[0].slot};
   assign rsp_tlast  = res_ff[0].last;

   assign head_slot = cell_entry[0];

   // A pop at the head is a shift that starts below cell zero.
   assign cell_shift[0] = pop;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_queue
      assign cell_occupied[i] = (CNT_W'(i) < queue_count_ff);
      assign cell_push[i]     = queue_ctrl.push && (CNT_W'(i) == queue_count_ff);
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign cell_next[i] = '0;
      end else begin : g_body
         assign cell_next[i] = cell_entry[i+1];
      end

      sdps_cell u_cell (
         .clock         (clock),
         .ctrl_in       (queue_ctrl),
         .occupied_in   (cell_occupied[i]),
         .push_here_in  (cell_push[i]),
         .next_entry_in (cell_next[i]),
         .shift_in      (cell_shift[i]),
         .entry_out     (cell_entry[i]),
         .shift_out     (cell_shift[i+1])
      );
   end

   // Decision logic for one request. Everything it changes is registered at
   // the edge where the request is taken; the resulting commands go to the
   // response buffer at the same edge.
   always_comb begin
      spin_valid_in    = spin_valid_ff;
      spin_slot_in     = spin_slot_ff;
      spin_timer_in    = spin_timer_ff;
      queue_count_in   = queue_count_ff;
      queued_mask_in   = queued_mask_ff;
      pop              = 1'b0;
      queue_ctrl       = '0;
      queue_ctrl.slot  = req_slot;

      res_in[0] = res_ff[0];
      res_in[1] = res_ff[1];
      res_cnt_in = res_cnt_ff;
      if (rsp_take) begin
         res_in[0]  = res_ff[1];
         res_cnt_in = res_cnt_ff - RES_CNT_W'(1);
      end

      if (req_accept) begin
         res_cnt_in = RES_CNT_W'(0);
         case (cmd_type'(req_tuser))
            CMD_TICK: begin
               // A tick only counts while a drive spins up; at expiry the
               // queue head, if any, is started in its place.
               if (spin_valid_ff) begin
                  if (spin_timer_ff > TICK_W'(1)) begin
                     spin_timer_in = spin_timer_ff - TICK_W'(1);
                  end else if (queue_count_ff != CNT_W'(0)) begin
                     pop            = 1'b1;
                     spin_slot_in   = head_slot;
                     spin_timer_in  = spin_ticks_ff;
                     queue_count_in = queue_count_ff - CNT_W'(1);
                     queued_mask_in = queued_mask_ff & ~(NUM_SLOTS'(1) << head_slot);
                     res_in[0]      = '{slot: head_slot, turn_on: 1'b1, last: 1'b1};
                     res_cnt_in     = RES_CNT_W'(1);
                  end else begin
                     spin_valid_in = 1'b0;
                     spin_slot_in  = '0;
                     spin_timer_in = '0;
                  end
               end
            end
            CMD_PRESENCE: begin
               if (req_present) begin
                  if (!spin_valid_ff) begin
                     // Nothing spins up, so the new drive starts at once.
                     spin_valid_in = 1'b1;
                     spin_slot_in  = req_slot;
                     spin_timer_in = spin_ticks_ff;
                     res_in[0]     = '{slot: req_slot, turn_on: 1'b1, last: 1'b1};
                     res_cnt_in    = RES_CNT_W'(1);
                  end else if ((spin_slot_ff != req_slot) && !queued_mask_ff[req_slot] &&
                               (queue_count_ff < CNT_W'(NUM_SLOTS))) begin
                     queue_ctrl.push = 1'b1;
                     queue_count_in  = queue_count_ff + CNT_W'(1);
                     queued_mask_in  = queued_mask_ff | (NUM_SLOTS'(1) << req_slot);
                  end
               end else begin
                  // Removal: the slot leaves the queue and is switched off.
                  queue_ctrl.remove = 1'b1;
                  queued_mask_in    = queued_mask_ff & ~(NUM_SLOTS'(1) << req_slot);
                  if (queued_mask_ff[req_slot]) begin
                     queue_count_in = queue_count_ff - CNT_W'(1);
                  end
                  res_in[0]  = '{slot: req_slot, turn_on: 1'b0, last: 1'b1};
                  res_cnt_in = RES_CNT_W'(1);
                  if (spin_valid_ff && (spin_slot_ff == req_slot)) begin
                     // The spinning drive went away: cancel its timer and
                     // hand the spin-up to the queue head, if there is one.
                     // A spinning slot is never queued, so no drop and pop
                     // meet in the same request.
                     spin_valid_in = 1'b0;
                     spin_slot_in  = '0;
                     spin_timer_in = '0;
                     if (queue_count_ff != CNT_W'(0)) begin
                        pop            = 1'b1;
                        spin_valid_in  = 1'b1;
                        spin_slot_in   = head_slot;
                        spin_timer_in  = spin_ticks_ff;
                        queue_count_in = queue_count_ff - CNT_W'(1);
                        queued_mask_in = queued_mask_ff & ~(NUM_SLOTS'(1) << req_slot)
                                         & ~(NUM_SLOTS'(1) << head_slot);
                        res_in[0]      = '{slot: req_slot, turn_on: 1'b0, last: 1'b0};
                        res_in[1]      = '{slot: head_slot, turn_on: 1'b1, last: 1'b1};
                        res_cnt_in     = RES_CNT_W'(2);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_ticks_ff  <= SPIN_RESET_TICKS;
         spin_valid_ff  <= 1'b0;
         spin_slot_ff   <= '0;
         spin_timer_ff  <= '0;
         queue_count_ff <= '0;
         queued_mask_ff <= '0;
         res_cnt_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            spin_ticks_ff <= csr_wr_data;
         end
         spin_valid_ff  <= spin_valid_in;
         spin_slot_ff   <= spin_slot_in;
         spin_timer_ff  <= spin_timer_in;
         queue_count_ff <= queue_count_in;
         queued_mask_ff <= queued_mask_in;
         res_cnt_ff     <= res_cnt_in;
      end
   end

   // The buffered commands themselves carry no reset.
   always_ff @(posedge clock) begin
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
   end

endmodule

`default_nettype wire

// File: verif/staggered_drive_power_sequencer_tb.sv
`timescale 1ns / 1ps

module staggered_drive_power_sequencer_tb;
   import sdps_pkg::*;

   // The run is stopped here whatever state it is in.
   localparam int CYCLE_LIMIT = 400000;
   // Responses are registered and a request gives at most two commands,
   // so a handful of quiet cycles is ample before touching the register.
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD_CYCLES = 80;

   // One request as the sender sees it: a presence change or a tick.
   typedef struct {
      cmd_type           cmd;
      logic [SLOT_W-1:0] slot;
      logic              present;
   } drive_request_type;

   // One power switch command as the block should emit it.
   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              turn_on;
      logic              last;
   } power_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [1:0] slot, [2] present, [7:3] zero
   logic        req_tuser = 1'b0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [1:0] power_slot, [2] turn_on, [7:3] zero
   logic        rsp_tlast;

   staggered_drive_power_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Requests waiting to be offered, and the power commands the sequencer
   // owes us, oldest first.
   drive_request_type pending_requests[$];
   power_cmd_type     power_cmds_due[$];

   int  reqs_queued = 0;     // written by the stimulus process only
   int  reqs_taken = 0;      // written by the driver only
   int  long_holds_asked = 0;
   int  long_holds_done = 0;
   int  cycle_count = 0;
   bit  no_idling = 1'b0;
   bit  failed = 1'b0;

   // Our own view of the sequencer: the spin-up register, the slot that is
   // currently spinning up with its remaining ticks, and the FIFO of slots
   // waiting for their turn together with a mask of who is in it.
   logic [TICK_W-1:0]    spin_ticks = SPIN_RESET_TICKS;
   logic                 spinning = 1'b0;
   logic [SLOT_W-1:0]    spin_slot = '0;
   logic [TICK_W-1:0]    spin_left = '0;
   logic [SLOT_W-1:0]    waiting_slots[$];
   logic [NUM_SLOTS-1:0] waiting_mask = '0;

   function automatic void owe_power_cmd(logic [SLOT_W-1:0] s, logic on, logic fin);
      power_cmd_type pc;
      pc.slot = s;
      pc.turn_on = on;
      pc.last = fin;
      power_cmds_due.push_back(pc);
   endfunction

   function automatic void start_spin(logic [SLOT_W-1:0] s);
      spinning = 1'b1;
      spin_slot = s;
      // A spin-up time of zero is loaded as is and runs out on the next tick.
      spin_left = spin_ticks;
   endfunction

   // Moves the head of the waiting FIFO into the spin-up position.
   function automatic logic [SLOT_W-1:0] promote_head();
      logic [SLOT_W-1:0] head;
      head = waiting_slots.pop_front();
      waiting_mask[head] = 1'b0;
      start_spin(head);
      return head;
   endfunction

   // Works out the power commands one accepted request causes and brings the
   // sequencer state up to date.
   function automatic void sequence_request(drive_request_type r);
      logic [SLOT_W-1:0] head;
      if (r.cmd == CMD_TICK) begin
         // A tick with nothing spinning up does nothing at all.
         if (spinning) begin
            if (spin_left > 1) begin
               spin_left = spin_left - 1'b1;
            end else begin
               spinning = 1'b0;
               spin_slot = '0;
               spin_left = '0;
               // Expiry with nobody waiting just frees the spin-up position.
               if (waiting_slots.size() != 0) begin
                  head = promote_head();
                  owe_power_cmd(head, 1'b1, 1'b1);
               end
            end
         end
      end else if (r.present) begin
         if (!spinning) begin
            start_spin(r.slot);
            owe_power_cmd(r.slot, 1'b1, 1'b1);
         end else if (spin_slot != r.slot && !waiting_mask[r.slot] &&
                      waiting_slots.size() < NUM_SLOTS) begin
            // Another drive is spinning up, so this one waits silently.
            waiting_slots.push_back(r.slot);
            waiting_mask[r.slot] = 1'b1;
         end
      end else begin
         for (int i = waiting_slots.size() - 1; i >= 0; i--) begin
            if (waiting_slots[i] == r.slot) waiting_slots.delete(i);
         end
         waiting_mask[r.slot] = 1'b0;
         if (spinning && spin_slot == r.slot) begin
            spinning = 1'b0;
            spin_slot = '0;
            spin_left = '0;
            if (waiting_slots.size() != 0) begin
               // Removing the spinning drive hands its turn straight on, so
               // the power-off is not the last command of this request.
               owe_power_cmd(r.slot, 1'b0, 1'b0);
               head = promote_head();
               owe_power_cmd(head, 1'b1, 1'b1);
               return;
            end
         end
         // Every removal powers the slot off, even one that was never on.
         owe_power_cmd(r.slot, 1'b0, 1'b1);
      end
   endfunction

   // Request driver: takes the next pending request whenever the bus is free,
   // with random idle bursts unless they are switched off.
   int idle_left = 0;

   always @(posedge clock) begin
      drive_request_type r;
      logic              offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.cmd = cmd_type'(req_tuser);
            r.slot = req_tdata[SLOT_W-1:0];
            r.present = req_tdata[2];
            sequence_request(r);
            reqs_taken++;
         end
         // A request that has not been taken stays on the bus unchanged.
         if (!(req_tvalid && !req_tready)) begin
            offer = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (!no_idling && $urandom_range(0, 9) == 0) begin
               idle_left = $urandom_range(0, 5);
            end else if (pending_requests.size() != 0) begin
               r = pending_requests.pop_front();
               req_tdata <= {5'b0, r.present, r.slot};
               req_tuser <= r.cmd;
               offer = 1'b1;
            end
            req_tvalid <= offer;
         end
      end
   end

   // Response monitor: checks every accepted command against the oldest one
   // owed, and throttles rsp_tready with short random stalls and, when asked,
   // one long hold-off so that the response buffer fills and the request
   // side backs up.
   int hold_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      power_cmd_type pc;
      logic          ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (power_cmds_due.size() == 0) begin
               $display("%0t: power command with nothing owed: slot %0d on %0b last %0b",
                        $time, rsp_tdata[1:0], rsp_tdata[2], rsp_tlast);
               failed = 1'b1;
            end else begin
               pc = power_cmds_due.pop_front();
               if (rsp_tdata !== {5'b0, pc.turn_on, pc.slot} || rsp_tlast !== pc.last) begin
                  $display("%0t: power command mismatch: expected slot %0d on %0b last %0b, %s",
                           $time, pc.slot, pc.turn_on, pc.last, "got");
                  $display("%0t:   tdata 0x%02h (slot %0d on %0b) last %0b",
                           $time, rsp_tdata, rsp_tdata[1:0], rsp_tdata[2], rsp_tlast);
                  failed = 1'b1;
               end
            end
         end
         ready = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
         end else if (long_holds_asked > long_holds_done) begin
            long_holds_done++;
            hold_left = LONG_HOLD_CYCLES - 1;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
         end else begin
            ready = 1'b1;
         end
         rsp_tready <= ready;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic add_request(cmd_type c, logic [SLOT_W-1:0] s, logic p);
      drive_request_type r;
      r.cmd = c;
      r.slot = s;
      r.present = p;
      pending_requests.push_back(r);
      reqs_queued++;
   endtask

   // Random traffic: plenty of ticks so that short spin-up times expire
   // often, inserts to build up the waiting FIFO and removals to break it up.
   task automatic add_random_requests(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            add_request(CMD_TICK, SLOT_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         else if (pick < 75)
            add_request(CMD_PRESENCE, SLOT_W'($urandom_range(0, 3)), 1'b1);
         else
            add_request(CMD_PRESENCE, SLOT_W'($urandom_range(0, 3)), 1'b0);
      end
   endtask

   // Blocks until every queued request has been taken and every owed command
   // has arrived, then lets the block settle.
   task automatic wait_until_quiet();
      do @(posedge clock);
      while (reqs_taken != reqs_queued || power_cmds_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_spin_ticks(logic [TICK_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      spin_ticks = v;
   endtask

   initial begin
      logic [TICK_W-1:0] phase_ticks[8];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset spin-up time: fill the FIFO, try duplicate inserts of a waiting and of
      // the spinning slot, drop a waiting slot, pull the spinning one twice so its
      // turn passes on and once with none left, then an idle removal and an idle tick.
      add_request(CMD_PRESENCE, 2'd0, 1'b1);
      add_request(CMD_PRESENCE, 2'd1, 1'b1);
      add_request(CMD_PRESENCE, 2'd1, 1'b1);
      add_request(CMD_PRESENCE, 2'd0, 1'b1);
      add_request(CMD_PRESENCE, 2'd2, 1'b1);
      add_request(CMD_PRESENCE, 2'd3, 1'b1);
      add_request(CMD_PRESENCE, 2'd2, 1'b0);
      add_request(CMD_TICK, 2'd3, 1'b1);
      add_request(CMD_PRESENCE, 2'd0, 1'b0);
      add_request(CMD_PRESENCE, 2'd1, 1'b0);
      add_request(CMD_PRESENCE, 2'd3, 1'b0);
      add_request(CMD_PRESENCE, 2'd3, 1'b0);
      add_request(CMD_TICK, 2'd0, 1'b0);
      wait_until_quiet();

      // Shortest spin-up: expiry with a slot waiting, then with nobody left.
      write_spin_ticks(TICK_W'(1));
      add_request(CMD_PRESENCE, 2'd0, 1'b1);
      add_request(CMD_PRESENCE, 2'd1, 1'b1);
      add_request(CMD_TICK, 2'd0, 1'b0);
      add_request(CMD_TICK, 2'd0, 1'b0);
      add_request(CMD_TICK, 2'd0, 1'b0);
      wait_until_quiet();

      // A spin-up time of zero must behave as one tick.
      write_spin_ticks('0);
      add_request(CMD_PRESENCE, 2'd2, 1'b1);
      add_request(CMD_PRESENCE, 2'd3, 1'b1);
      add_request(CMD_TICK, 2'd1, 1'b1);
      add_request(CMD_TICK, 2'd2, 1'b0);
      add_request(CMD_PRESENCE, 2'd3, 1'b0);
      wait_until_quiet();

      // Longest spin-up: ticks only count down, removals drive everything.
      write_spin_ticks('1);
      add_request(CMD_PRESENCE, 2'd1, 1'b1);
      add_request(CMD_PRESENCE, 2'd2, 1'b1);
      add_request(CMD_TICK, 2'd0, 1'b0);
      add_request(CMD_PRESENCE, 2'd1, 1'b0);
      add_request(CMD_PRESENCE, 2'd2, 1'b0);
      wait_until_quiet();

      // Random phases over a spread of spin-up times. Each phase runs in two
      // halves with the sender paused until everything owed has come back.
      // The last phase runs with no idling on either side.
      phase_ticks[0] = TICK_W'(2);
      phase_ticks[1] = TICK_W'(1);
      phase_ticks[2] = TICK_W'(3);
      phase_ticks[3] = TICK_W'($urandom_range(4, 12));
      phase_ticks[4] = '1;
      phase_ticks[5] = '0;
      phase_ticks[6] = TICK_W'($urandom_range(1, 6));
      phase_ticks[7] = TICK_W'(2);
      for (int ph = 0; ph < 8; ph++) begin
         write_spin_ticks(phase_ticks[ph]);
         if (ph == 7) no_idling = 1'b1;
         add_random_requests(125);
         // Stall the response side for a long stretch while requests keep
         // coming, so the block fills up and pushes back on the requests.
         if (ph == 2 || ph == 5) long_holds_asked++;
         wait_until_quiet();
         add_random_requests(125);
         wait_until_quiet();
      end

      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
